// ===== sv/gba_pkg.sv =====
// Shared types and constants for the group-by aggregator.
package gba_pkg;

	localparam int unsigned DataWidth = 32;

	typedef enum logic [1:0] {
		MODE_SUM = 2'd0,
		MODE_MIN = 2'd1,
		MODE_MAX = 2'd2,
		MODE_AVG = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		STAT_ACCUMULATED = 2'd0,
		STAT_DROPPED     = 2'd1,
		STAT_EMITTED     = 2'd2,
		STAT_DONE        = 2'd3
	} status_t;

	typedef enum logic {
		OP_ACCUMULATE = 1'b0,
		OP_READ       = 1'b1
	} op_t;

	// One classified command travelling from the front end to the engine.
	typedef struct packed {
		op_t                  op;
		logic [DataWidth-1:0] key;
		logic [DataWidth-1:0] value;
	} item_t;

	// One row of the group table as it is stored in memory.
	typedef struct packed {
		logic [DataWidth-1:0] key;
		logic [DataWidth-1:0] acc;
		logic [DataWidth-1:0] count;
	} entry_t;

	localparam int unsigned EntryWidth = $bits(entry_t);

endpackage

// ===== sv/group_by_aggregator.sv =====
// Top level of the group-by aggregator: front queue, engine and mode register.
//
//   channel   handshake             payload
//   input     push / full           cmd, group_key, agg_value
//   result    empty / pop           status, out_key, out_aggregate, last_group
//   config    cfg_valid / cfg_ready agg_mode
//
// With the engine free, an accumulate row is compared with the stored groups in key order; a new
// key is written at its place after each larger group is moved up with a read and a write.
// The table memory has one read port. In average mode a read also waits for the bit-serial
// divider. Reset empties the table at once; the memory needs no clearing pass.
// The input queue holds two transactions; the engine takes the next one only after the
// waiting result has been popped, so a stalled receiver backs up into full.
module group_by_aggregator #(
	parameter int unsigned MAX_GROUPS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        cmd,
	input  logic [31:0] group_key,
	input  logic [31:0] agg_value,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  status,
	output logic [31:0] out_key,
	output logic [31:0] out_aggregate,
	output logic        last_group,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  agg_mode
);

	gba_pkg::mode_t mode_q;
	gba_pkg::item_t item;
	logic           item_valid;
	logic           item_pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= gba_pkg::MODE_SUM;
		end else if (cfg_valid && cfg_ready) begin
			mode_q <= gba_pkg::mode_t'(agg_mode);
		end
	end

	gba_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.cmd       (cmd),
		.group_key (group_key),
		.agg_value (agg_value),
		.item_valid(item_valid),
		.item      (item),
		.item_pop  (item_pop)
	);

	gba_engine #(
		.MAX_GROUPS(MAX_GROUPS)
	) u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.mode         (mode_q),
		.item_valid   (item_valid),
		.item         (item),
		.item_pop     (item_pop),
		.empty        (empty),
		.pop          (pop),
		.status       (status),
		.out_key      (out_key),
		.out_aggregate(out_aggregate),
		.last_group   (last_group)
	);

endmodule

// ===== sv/gba_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module gba_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/gba_front.sv =====
// Front end: accepts input transactions, classifies them and queues them for the engine.
module gba_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	output logic                             full,
	input  logic                             cmd,
	input  logic [gba_pkg::DataWidth-1:0]    group_key,
	input  logic [gba_pkg::DataWidth-1:0]    agg_value,
	output logic                             item_valid,
	output gba_pkg::item_t                   item,
	input  logic                             item_pop
);

	gba_pkg::item_t slot_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;
	logic           do_push;
	logic           do_pop;
	gba_pkg::item_t new_item;

	assign full       = (count_q == 2'd2);
	assign item_valid = (count_q != 2'd0);
	assign item       = slot_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = item_pop && item_valid;

	always_comb begin
		new_item.op    = cmd ? gba_pkg::OP_READ : gba_pkg::OP_ACCUMULATE;
		new_item.key   = group_key;
		new_item.value = agg_value;
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== sv/gba_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
module gba_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [gba_pkg::DataWidth-1:0] dividend,
	input  logic [gba_pkg::DataWidth-1:0] divisor,
	output logic                          done,
	output logic [gba_pkg::DataWidth-1:0] quotient
);

	localparam int unsigned W  = gba_pkg::DataWidth;
	localparam int unsigned CW = $clog2(W + 1);

	logic [W:0]    rem_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  dsr_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [W:0]    rem_sh;
	logic [W:0]    trial;

	assign rem_sh   = {rem_q[W-1:0], quo_q[W-1]};
	assign trial    = rem_sh - {1'b0, dsr_q};
	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			if (!trial[W]) begin
				rem_q <= trial;
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= CW'(W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

// ===== sv/gba_engine.sv =====
// Back end: searches, folds, inserts and reads out groups in the sorted table.
module gba_engine #(
	parameter int unsigned MAX_GROUPS = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  gba_pkg::mode_t                mode,
	input  logic                          item_valid,
	input  gba_pkg::item_t                item,
	output logic                          item_pop,
	output logic                          empty,
	input  logic                          pop,
	output logic [1:0]                    status,
	output logic [gba_pkg::DataWidth-1:0] out_key,
	output logic [gba_pkg::DataWidth-1:0] out_aggregate,
	output logic                          last_group
);

	localparam int unsigned W  = gba_pkg::DataWidth;
	localparam int unsigned AW = $clog2(MAX_GROUPS);
	localparam int unsigned CW = $clog2(MAX_GROUPS + 1);
	localparam int unsigned EntryBits = gba_pkg::EntryWidth;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SH_RD,
		ST_SH_WR,
		ST_INS,
		ST_RDOUT,
		ST_DIV
	} state_t;

	state_t          state_q;
	logic [W-1:0]    key_q;
	logic [W-1:0]    val_q;
	logic [AW-1:0]   pos_q;
	logic [AW-1:0]   idx_q;
	logic [CW-1:0]   n_q;
	logic [AW-1:0]   rp_q;
	logic            neg_q;
	logic            last_q;
	logic            out_valid_q;
	gba_pkg::status_t status_q;
	logic [W-1:0]    out_key_q;
	logic [W-1:0]    out_agg_q;
	logic            last_group_q;

	logic            take;
	logic [AW-1:0]   rd_pos;
	logic [AW-1:0]   raddr;
	logic            we;
	logic [AW-1:0]   waddr;
	gba_pkg::entry_t wdata;
	gba_pkg::entry_t rdata;
	logic [EntryBits-1:0] rdata_raw;
	logic            full_table;
	logic            pos_at_end;
	logic            key_less;
	logic [W-1:0]    folded;
	logic            rd_last;
	logic [W-1:0]    mag;
	logic            div_start;
	logic            div_done;
	logic [W-1:0]    div_q;

	assign take       = (state_q == ST_IDLE) && item_valid && !out_valid_q;
	assign item_pop   = take;
	assign full_table = (n_q == CW'(MAX_GROUPS));
	assign pos_at_end = ((CW'(pos_q) + CW'(1)) == n_q);
	assign rd_pos     = (CW'(rp_q) >= n_q) ? AW'(n_q - CW'(1)) : rp_q;
	assign rdata      = gba_pkg::entry_t'(rdata_raw);
	assign key_less   = $signed(rdata.key) < $signed(key_q);
	assign rd_last    = ((CW'(pos_q) + CW'(1)) == n_q);
	assign mag        = rdata.acc[W-1] ? (W'(0) - rdata.acc) : rdata.acc;
	assign div_start  = (state_q == ST_RDOUT) && (mode == gba_pkg::MODE_AVG)
		&& (rdata.count != '0);

	always_comb begin
		case (mode)
			gba_pkg::MODE_MIN:
				folded = ($signed(val_q) < $signed(rdata.acc)) ? val_q : rdata.acc;
			gba_pkg::MODE_MAX:
				folded = ($signed(rdata.acc) < $signed(val_q)) ? val_q : rdata.acc;
			default:
				folded = rdata.acc + val_q;
		endcase
	end

	// The read address is issued in the cycle before the state that uses the data.
	always_comb begin
		case (state_q)
			ST_IDLE:  raddr = (item.op == gba_pkg::OP_READ) ? rd_pos : '0;
			ST_SCAN:  raddr = pos_q + AW'(1);
			ST_SH_RD: raddr = idx_q - AW'(1);
			default:  raddr = pos_q;
		endcase
	end

	always_comb begin
		we          = 1'b0;
		waddr       = pos_q;
		wdata       = rdata;
		case (state_q)
			ST_SCAN: begin
				if (rdata.key == key_q) begin
					we          = 1'b1;
					wdata.acc   = folded;
					wdata.count = rdata.count + W'(1);
				end
			end
			ST_SH_WR: begin
				we    = 1'b1;
				waddr = idx_q;
			end
			ST_INS: begin
				we          = 1'b1;
				wdata.key   = key_q;
				wdata.acc   = val_q;
				wdata.count = W'(1);
			end
			default: we = 1'b0;
		endcase
	end

	gba_ram #(
		.WIDTH(EntryBits),
		.DEPTH(MAX_GROUPS)
	) u_table (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata_raw)
	);

	gba_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(mag),
		.divisor (rdata.count),
		.done    (div_done),
		.quotient(div_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			n_q          <= '0;
			rp_q         <= '0;
			out_valid_q  <= 1'b0;
			key_q        <= '0;
			val_q        <= '0;
			pos_q        <= '0;
			idx_q        <= '0;
			neg_q        <= 1'b0;
			last_q       <= 1'b0;
			status_q     <= gba_pkg::STAT_ACCUMULATED;
			out_key_q    <= '0;
			out_agg_q    <= '0;
			last_group_q <= 1'b0;
		end else begin
			if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						key_q <= item.key;
						val_q <= item.value;
						pos_q <= '0;
						idx_q <= '0;
						if (item.op == gba_pkg::OP_ACCUMULATE) begin
							state_q <= (n_q == '0) ? ST_INS : ST_SCAN;
						end else if (n_q == '0) begin
							rp_q         <= '0;
							out_valid_q  <= 1'b1;
							status_q     <= gba_pkg::STAT_DONE;
							out_key_q    <= '0;
							out_agg_q    <= '0;
							last_group_q <= 1'b0;
						end else begin
							pos_q   <= rd_pos;
							state_q <= ST_RDOUT;
						end
					end
				end
				ST_SCAN: begin
					if (rdata.key == key_q) begin
						out_valid_q  <= 1'b1;
						status_q     <= gba_pkg::STAT_ACCUMULATED;
						out_key_q    <= '0;
						out_agg_q    <= '0;
						last_group_q <= 1'b0;
						state_q      <= ST_IDLE;
					end else if (key_less && !pos_at_end) begin
						pos_q <= pos_q + AW'(1);
					end else if (full_table) begin
						out_valid_q  <= 1'b1;
						status_q     <= gba_pkg::STAT_DROPPED;
						out_key_q    <= '0;
						out_agg_q    <= '0;
						last_group_q <= 1'b0;
						state_q      <= ST_IDLE;
					end else if (key_less) begin
						// The new key goes after every open group.
						pos_q   <= AW'(n_q);
						state_q <= ST_INS;
					end else begin
						idx_q   <= AW'(n_q);
						state_q <= ST_SH_RD;
					end
				end
				ST_SH_RD: begin
					state_q <= ST_SH_WR;
				end
				ST_SH_WR: begin
					idx_q   <= idx_q - AW'(1);
					state_q <= ((idx_q - AW'(1)) == pos_q) ? ST_INS : ST_SH_RD;
				end
				ST_INS: begin
					n_q          <= n_q + CW'(1);
					out_valid_q  <= 1'b1;
					status_q     <= gba_pkg::STAT_ACCUMULATED;
					out_key_q    <= '0;
					out_agg_q    <= '0;
					last_group_q <= 1'b0;
					state_q      <= ST_IDLE;
				end
				ST_RDOUT: begin
					if (rd_last) begin
						n_q  <= '0;
						rp_q <= '0;
					end else begin
						rp_q <= pos_q + AW'(1);
					end
					if (div_start) begin
						neg_q     <= rdata.acc[W-1];
						last_q    <= rd_last;
						out_key_q <= rdata.key;
						state_q   <= ST_DIV;
					end else begin
						out_valid_q  <= 1'b1;
						status_q     <= gba_pkg::STAT_EMITTED;
						out_key_q    <= rdata.key;
						out_agg_q    <= rdata.acc;
						last_group_q <= rd_last;
						state_q      <= ST_IDLE;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						out_valid_q  <= 1'b1;
						status_q     <= gba_pkg::STAT_EMITTED;
						out_agg_q    <= neg_q ? (W'(0) - div_q) : div_q;
						last_group_q <= last_q;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign empty         = !out_valid_q;
	assign status        = status_q;
	assign out_key       = out_key_q;
	assign out_aggregate = out_agg_q;
	assign last_group    = last_group_q;

endmodule

// ===== sv/gba_checker.sv =====
// Port-level checks for the group-by aggregator, bound to the top level.
module gba_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic [1:0]  status,
	input logic [31:0] out_key,
	input logic [31:0] out_aggregate,
	input logic        last_group
);

	// Only an emitted group carries key, aggregate and last flag.
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status != gba_pkg::STAT_EMITTED) |->
			(out_key == 32'd0 && out_aggregate == 32'd0 && !last_group))
		else $error("non-group result carries payload");

	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(status) && $stable(out_aggregate)))
		else $error("waiting result changed");

	assert property (@(posedge clk) !arst_n |=> empty)
		else $error("result shown during reset");

endmodule

bind group_by_aggregator gba_checker u_gba_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.empty        (empty),
	.pop          (pop),
	.status       (status),
	.out_key      (out_key),
	.out_aggregate(out_aggregate),
	.last_group   (last_group)
);
